FILE: hw/rtl/trpm_pkg.sv
// ----------------------------------------------------------------------------
// trpm_pkg - shared types and constants of the tachometer
// Sequencer states, register indexes, fixed-point limits and divider sizes.
// ----------------------------------------------------------------------------
package trpm_pkg;

    // Divider: 49-bit dividend, 48-bit divisor, one quotient bit a cycle
    localparam int unsigned DIV_NW    = 49;
    localparam int unsigned DIV_DW    = 48;
    localparam int unsigned DIV_STEPS = DIV_NW;
    localparam int unsigned DIV_CW    = $clog2(DIV_STEPS + 1);

    // Numerator of rpm: 60e6 * 256
    localparam logic [DIV_NW-1:0] RPM_NUM = 49'd15360000000;
    localparam logic [25:0] RPM_MAX = 26'h3FFFFFF;
    localparam logic [22:0] VEL_MAX = 23'h7FFFFF;
    localparam logic [39:0] ACC_MAX = 40'h7FFFFFFFFF;
    localparam logic [39:0] ACC_MIN = 40'h8000000000;
    localparam logic [19:0] ACC_SCALE = 20'd1000000;

    // Register indexes
    localparam logic [2:0] REG_TEETH    = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE = 3'd1;
    localparam logic [2:0] REG_MINPER   = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_VCOEF    = 3'd4;

    // Input kinds
    localparam logic MODE_EDGE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RMUL,
        ST_RSTART,
        ST_RWAIT,
        ST_VMUL,
        ST_VSAT,
        ST_AMUL,
        ST_ASTART,
        ST_AWAIT,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hw/rtl/tachometer_rpm_acceleration_top.sv
// ----------------------------------------------------------------------------
// tachometer_rpm_acceleration_top - period-measuring tachometer
// Pulse debounce, rpm, roller angular velocity and acceleration.
// ----------------------------------------------------------------------------
// A timeout word or an edge without speed update goes straight to the output
// register; an rpm update can use the shared 49-step divider, and an
// acceleration update uses it a second time. One word in flight at a time.
// Reset (synchronous, active low) clears the state and flags, output valid
// included, and loads the register defaults; no clearing pass.
module tachometer_rpm_acceleration_top #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // [31:0] now_us
    input  logic          s_tuser,   // [0] mode
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // [25:0] rpm, [48:26] angular_velocity,
                                     // [88:49] angular_acceleration,
                                     // [120:89] pulse_count, rest zero
    output logic [1:0]    m_tuser,   // [0] pulse_accepted, [1] timed_out
    // configuration
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    localparam int unsigned TW = TIME_WIDTH;

    trpm_pkg::t_state r_state, n_state;

    // config registers
    logic [7:0]  r_teeth;
    logic [15:0] r_debounce;
    logic [15:0] r_minper;
    logic [31:0] r_timeout;
    logic [23:0] r_vcoef;

    // state
    logic [TW-1:0] r_last_pulse;
    logic [TW-1:0] r_last_upd;
    logic [31:0]   r_count;
    logic [25:0]   r_rpm;
    logic [22:0]   r_vel;
    logic [22:0]   r_prev_vel;
    logic [39:0]   r_acc;
    logic          r_seen;

    // work registers
    logic [TW-1:0] r_now;
    logic [TW-1:0] r_since;
    logic [47:0]   r_den;
    logic [49:0]   r_vprod;
    logic [42:0]   r_num;
    logic          r_neg;
    logic          r_acc_flag;
    logic          r_tim_flag;

    // output register
    logic          r_oval;
    logic [127:0]  r_odata;
    logic [1:0]    r_ouser;

    logic                         w_s_acc;
    logic [TW-1:0]                w_now;
    logic [TW-1:0]                w_since;
    logic [63:0]                  w_since64;
    logic [TW-1:0]                w_dt;
    logic [63:0]                  w_dt64;
    logic [63:0]                  w_rs64;
    logic                         w_out_free;
    logic                         w_div_start;
    logic [trpm_pkg::DIV_NW-1:0]  w_div_n;
    logic [trpm_pkg::DIV_DW-1:0]  w_div_d;
    trpm_pkg::t_div_rsp           w_div;
    logic [29:0]                  w_vq;
    logic [trpm_pkg::DIV_NW-1:0]  w_mag;
    logic [39:0]                  w_acc_new;
    logic [22:0]                  w_dv;

    assign w_s_acc    = s_tvalid && s_tready;
    assign w_now      = TW'(s_tdata);
    assign w_since    = w_now - r_last_pulse;
    assign w_since64  = 64'(w_since);
    assign w_rs64     = 64'(r_since);
    assign w_dt       = r_now - r_last_upd;
    assign w_dt64     = 64'(w_dt);
    assign w_out_free = !r_oval || m_tready;
    assign o_cfg_ready = 1'b1;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teeth    <= 8'd20;
            r_debounce <= 16'd200;
            r_minper   <= 16'd250;
            r_timeout  <= 32'd1000000;
            r_vcoef    <= 24'd1756906;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                trpm_pkg::REG_TEETH:    r_teeth    <= i_cfg_data[7:0];
                trpm_pkg::REG_DEBOUNCE: r_debounce <= i_cfg_data[15:0];
                trpm_pkg::REG_MINPER:   r_minper   <= i_cfg_data[15:0];
                trpm_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                trpm_pkg::REG_VCOEF:    r_vcoef    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            trpm_pkg::ST_IDLE: begin
                if (w_s_acc) begin
                    if (s_tuser == trpm_pkg::MODE_EDGE &&
                        w_since64 > 64'(r_debounce) &&
                        w_since64 > 64'(r_minper))
                        n_state = trpm_pkg::ST_RMUL;
                    else
                        n_state = trpm_pkg::ST_DONE;
                end
            end
            trpm_pkg::ST_RMUL: begin
                if (r_teeth == 8'd0 || w_rs64[63:40] != 24'd0)
                    n_state = trpm_pkg::ST_VMUL;
                else
                    n_state = trpm_pkg::ST_RSTART;
            end
            trpm_pkg::ST_RSTART: n_state = trpm_pkg::ST_RWAIT;
            trpm_pkg::ST_RWAIT:  if (w_div.done) n_state = trpm_pkg::ST_VMUL;
            trpm_pkg::ST_VMUL:   n_state = trpm_pkg::ST_VSAT;
            trpm_pkg::ST_VSAT: begin
                if (r_seen && w_dt != '0)
                    n_state = trpm_pkg::ST_AMUL;
                else
                    n_state = trpm_pkg::ST_UPD;
            end
            trpm_pkg::ST_AMUL: begin
                if (w_dt64[63:40] != 24'd0)
                    n_state = trpm_pkg::ST_UPD;
                else
                    n_state = trpm_pkg::ST_ASTART;
            end
            trpm_pkg::ST_ASTART: n_state = trpm_pkg::ST_AWAIT;
            trpm_pkg::ST_AWAIT:  if (w_div.done) n_state = trpm_pkg::ST_UPD;
            trpm_pkg::ST_UPD:    n_state = trpm_pkg::ST_DONE;
            trpm_pkg::ST_DONE:   if (w_out_free) n_state = trpm_pkg::ST_IDLE;
            default:             n_state = trpm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready    = (r_state == trpm_pkg::ST_IDLE);
        w_div_start = 1'b0;
        w_div_n     = '0;
        w_div_d     = '0;
        case (r_state)
            trpm_pkg::ST_RSTART: begin
                w_div_start = 1'b1;
                w_div_n     = trpm_pkg::RPM_NUM + trpm_pkg::DIV_NW'(r_den >> 1);
                w_div_d     = r_den;
            end
            trpm_pkg::ST_ASTART: begin
                w_div_start = 1'b1;
                w_div_n     = trpm_pkg::DIV_NW'(r_num) + trpm_pkg::DIV_NW'(r_den >> 1);
                w_div_d     = r_den;
            end
            default: ;
        endcase
    end

    trpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_rsp      (w_div)
    );

    // Rounding and saturation
    assign w_vq  = 30'((r_vprod + 50'd524288) >> 20);
    assign w_mag = w_div.quotient;
    assign w_dv  = (r_vel < r_prev_vel) ? (r_prev_vel - r_vel) : (r_vel - r_prev_vel);

    always_comb begin
        if (r_neg) begin
            if (w_mag[48:40] != 9'd0 || (w_mag[39] && w_mag[38:0] != 39'd0))
                w_acc_new = trpm_pkg::ACC_MIN;
            else
                w_acc_new = 40'd0 - w_mag[39:0];
        end else begin
            if (w_mag[48:39] != 10'd0)
                w_acc_new = trpm_pkg::ACC_MAX;
            else
                w_acc_new = w_mag[39:0];
        end
    end

    // Datapath and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= trpm_pkg::ST_IDLE;
            r_last_pulse <= '0;
            r_last_upd <= '0;
            r_count    <= '0;
            r_rpm      <= '0;
            r_vel      <= '0;
            r_prev_vel <= '0;
            r_acc      <= '0;
            r_seen     <= 1'b0;
            r_acc_flag <= 1'b0;
            r_tim_flag <= 1'b0;
            r_oval     <= 1'b0;
        end else begin
            r_state <= n_state;
            // result word valid: load on done, drop once taken
            if (r_state == trpm_pkg::ST_DONE && w_out_free)
                r_oval <= 1'b1;
            else if (m_tready)
                r_oval <= 1'b0;
            case (r_state)
                trpm_pkg::ST_IDLE: begin
                    if (w_s_acc) begin
                        r_now      <= w_now;
                        r_since    <= w_since;
                        r_acc_flag <= 1'b0;
                        r_tim_flag <= 1'b0;
                        if (s_tuser == trpm_pkg::MODE_EDGE) begin
                            if (w_since64 > 64'(r_debounce)) begin
                                r_acc_flag   <= 1'b1;
                                r_count      <= r_count + 32'd1;
                                r_last_pulse <= w_now;
                            end
                        end else if (w_since64 > 64'(r_timeout)) begin
                            r_tim_flag <= 1'b1;
                            r_rpm      <= '0;
                            r_vel      <= '0;
                            r_prev_vel <= '0;
                            r_acc      <= '0;
                        end
                    end
                end
                trpm_pkg::ST_RMUL: begin
                    r_den <= 48'(w_rs64[39:0]) * 48'(r_teeth);
                    if (r_teeth == 8'd0)
                        r_rpm <= trpm_pkg::RPM_MAX;
                    else if (w_rs64[63:40] != 24'd0)
                        r_rpm <= '0;
                end
                trpm_pkg::ST_RWAIT: begin
                    if (w_div.done)
                        r_rpm <= (w_mag[48:26] != 23'd0) ? trpm_pkg::RPM_MAX : w_mag[25:0];
                end
                trpm_pkg::ST_VMUL: r_vprod <= 50'(r_rpm) * 50'(r_vcoef);
                trpm_pkg::ST_VSAT:
                    r_vel <= (w_vq[29:23] != 7'd0) ? trpm_pkg::VEL_MAX : w_vq[22:0];
                trpm_pkg::ST_AMUL: begin
                    r_neg <= (r_vel < r_prev_vel);
                    r_num <= 43'(w_dv) * 43'(trpm_pkg::ACC_SCALE);
                    r_den <= {4'd0, w_dt64[39:0], 4'd0};
                    if (w_dt64[63:40] != 24'd0)
                        r_acc <= '0;
                end
                trpm_pkg::ST_AWAIT: if (w_div.done) r_acc <= w_acc_new;
                trpm_pkg::ST_UPD: begin
                    r_prev_vel <= r_vel;
                    r_last_upd <= r_now;
                    r_seen     <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (r_state == trpm_pkg::ST_DONE && w_out_free) begin
            r_odata <= {7'd0, r_count, r_acc, r_vel, r_rpm};
            r_ouser <= {r_tim_flag, r_acc_flag};
        end
    end

    assign m_tvalid = r_oval;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_ouser;

    // Checks
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != trpm_pkg::ST_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == trpm_pkg::ST_RWAIT || r_state == trpm_pkg::ST_AWAIT))
        else $error("divider done outside wait");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("both accepted and timed out");

endmodule

FILE: hw/rtl/trpm_div.sv
// ----------------------------------------------------------------------------
// trpm_div - shared restoring divider
// Unsigned divide, one quotient bit per cycle, done pulses with the quotient.
// ----------------------------------------------------------------------------
module trpm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [trpm_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [trpm_pkg::DIV_DW-1:0]   i_divisor,
    output trpm_pkg::t_div_rsp            o_rsp
);

    logic [trpm_pkg::DIV_NW-1:0] r_rem;
    logic [trpm_pkg::DIV_NW-1:0] r_quo;
    logic [trpm_pkg::DIV_DW-1:0] r_div;
    logic [trpm_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [trpm_pkg::DIV_NW-1:0] w_shift;
    logic [trpm_pkg::DIV_NW-1:0] w_dext;
    logic                        w_ge;

    // One trial subtraction per cycle
    assign w_shift = {r_rem[trpm_pkg::DIV_NW-2:0], r_quo[trpm_pkg::DIV_NW-1]};
    assign w_dext  = {1'b0, r_div};
    assign w_ge    = (w_shift >= w_dext);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= trpm_pkg::DIV_CW'(trpm_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == trpm_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - w_dext) : w_shift;
            r_quo <= {r_quo[trpm_pkg::DIV_NW-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: verif/tachometer_rpm_acceleration_top_tb.sv
// ----------------------------------------------------------------------------
// tachometer_rpm_acceleration_top_tb - self-checking bench of the tachometer
// Pulse and timeout words go in from a queue with random gaps, results are
// checked field by field against a built-in predictor, across several
// register settings.
// ----------------------------------------------------------------------------
module tachometer_rpm_acceleration_top_tb;

    typedef struct packed {
        logic        mode;
        logic [31:0] now;
    } t_tick;

    typedef struct packed {
        logic [25:0] rpm;
        logic [22:0] vel;
        logic [39:0] acc;
        logic [31:0] cnt;
        logic        acc_ok;
        logic        tmo;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    tachometer_rpm_acceleration_top uut (.*);

    // predictor state and registers
    logic [31:0] p_last_pulse, p_count, p_last_upd;
    logic [25:0] p_rpm;
    logic [22:0] p_vel, p_prev_vel;
    logic signed [39:0] p_acc;
    logic p_seen;
    logic [7:0] r_teeth;
    logic [15:0] r_debounce, r_minper;
    logic [31:0] r_timeout;
    logic [23:0] r_vcoef;

    t_tick tick_q[$];
    t_reading reading_q[$];
    int errors = 0;
    int cycles = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_accepted = 0;
    int n_timeouts = 0;
    bit quiet = 1'b0;
    int s_gap = 0;
    int m_gap = 0;
    logic [31:0] t_now = '0;

    // clock, period 2
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [25:0] rpm_of(logic [31:0] ival);
        logic [63:0] den, q;
        if (r_teeth == 0) return trpm_pkg::RPM_MAX;
        den = 64'(ival) * r_teeth;
        q = (64'd15360000000 + den / 2) / den;
        return (q > 64'(trpm_pkg::RPM_MAX)) ? trpm_pkg::RPM_MAX : q[25:0];
    endfunction

    function automatic logic [22:0] vel_of(logic [25:0] rpm);
        logic [63:0] q;
        q = (64'(rpm) * r_vcoef + (64'd1 << 19)) >> 20;
        return (q > 64'(trpm_pkg::VEL_MAX)) ? trpm_pkg::VEL_MAX : q[22:0];
    endfunction

    function automatic logic signed [39:0] accel_of(logic [22:0] cur, logic [22:0] prv,
                                                    logic [31:0] dt);
        logic [63:0] dv, den, mag;
        bit neg;
        neg = cur < prv;
        dv = neg ? 64'(prv - cur) : 64'(cur - prv);
        den = 64'(dt) * 16;
        mag = (dv * 1000000 + den / 2) / den;
        if (neg) return (mag > 64'h80_0000_0000) ? trpm_pkg::ACC_MIN : 40'(-mag);
        return (mag > 64'(trpm_pkg::ACC_MAX)) ? trpm_pkg::ACC_MAX : mag[39:0];
    endfunction

    // advance the predictor by one word and queue the expected result
    task automatic tach_step(input t_tick t);
        t_reading r;
        logic [31:0] since, dt;
        r = '0;
        since = t.now - p_last_pulse;
        if (t.mode == trpm_pkg::MODE_EDGE) begin
            if (since > r_debounce) begin
                r.acc_ok = 1'b1;
                p_count++;
                p_last_pulse = t.now;
                if (since > r_minper) begin
                    p_rpm = rpm_of(since);
                    p_vel = vel_of(p_rpm);
                    dt = t.now - p_last_upd;
                    if (p_seen && dt != 0) p_acc = accel_of(p_vel, p_prev_vel, dt);
                    p_prev_vel = p_vel;
                    p_last_upd = t.now;
                    p_seen = 1'b1;
                end
            end
        end else if (since > r_timeout) begin
            r.tmo = 1'b1;
            p_rpm = '0;
            p_vel = '0;
            p_prev_vel = '0;
            p_acc = '0;
        end
        r.rpm = p_rpm;
        r.vel = p_vel;
        r.acc = p_acc;
        r.cnt = p_count;
        reading_q.push_back(r);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
    endtask

    // driver
    always @(posedge i_clk) begin
        cycles++;
        if (s_tvalid && s_tready) begin
            tach_step('{mode: s_tuser, now: s_tdata});
            n_sent++;
        end
        if (!s_tvalid || s_tready) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (tick_q.size() > 0 && i_rst_n) begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= tick_q.pop_front();
                if (!quiet && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reading e;
        if (m_tvalid && m_tready) begin
            if (reading_q.size() == 0) begin
                report("unexpected word", m_tdata[63:0], 0);
            end else begin
                e = reading_q.pop_front();
                n_checked++;
                if (m_tdata[25:0] != e.rpm) report("rpm", m_tdata[25:0], e.rpm);
                if (m_tdata[48:26] != e.vel) report("velocity", m_tdata[48:26], e.vel);
                if (m_tdata[88:49] != e.acc) report("accel", m_tdata[88:49], e.acc);
                if (m_tdata[120:89] != e.cnt) report("count", m_tdata[120:89], e.cnt);
                if (m_tuser[0] != e.acc_ok) report("accepted", m_tuser[0], e.acc_ok);
                if (m_tuser[1] != e.tmo) report("timed_out", m_tuser[1], e.tmo);
                n_accepted += e.acc_ok;
                n_timeouts += e.tmo;
            end
        end
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            m_gap = $urandom_range(1, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("timeout waiting for results");
            $display("tachometer_rpm_acceleration_top_tb: FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            trpm_pkg::REG_TEETH:    r_teeth = val[7:0];
            trpm_pkg::REG_DEBOUNCE: r_debounce = val[15:0];
            trpm_pkg::REG_MINPER:   r_minper = val[15:0];
            trpm_pkg::REG_TIMEOUT:  r_timeout = val;
            default:                r_vcoef = val[23:0];
        endcase
    endtask

    task automatic add(input logic mode, input logic [31:0] now);
        tick_q.push_back('{mode: mode, now: now});
    endtask

    // wait until every queued word is checked, then let the pipe drain
    task automatic drain();
        while (tick_q.size() > 0 || s_tvalid || reading_q.size() > 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // a random burst: mostly well spaced pulses around the current time
    task automatic burst(input int n, input int unsigned span);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: add(trpm_pkg::MODE_TIMEOUT, t_now + $urandom_range(0, span * 4));
                1: add(1'($urandom_range(0, 1)), $urandom());
                2: begin
                    t_now += $urandom_range(0, r_debounce + 2);
                    add(trpm_pkg::MODE_EDGE, t_now);
                end
                default: begin
                    t_now += $urandom_range(1, span);
                    add(trpm_pkg::MODE_EDGE, t_now);
                end
            endcase
        end
    endtask

    initial begin
        r_teeth = 8'd20;
        r_debounce = 16'd200;
        r_minper = 16'd250;
        r_timeout = 32'd1000000;
        r_vcoef = 24'd1756906;
        p_last_pulse = '0; p_count = '0; p_last_upd = '0;
        p_rpm = '0; p_vel = '0; p_prev_vel = '0; p_acc = '0; p_seen = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: debounce edges, min period, wrap, timeouts
        add(trpm_pkg::MODE_EDGE, 32'd200);
        add(trpm_pkg::MODE_EDGE, 32'd201);
        add(trpm_pkg::MODE_EDGE, 32'd451);
        add(trpm_pkg::MODE_EDGE, 32'd1000);
        add(trpm_pkg::MODE_EDGE, 32'd1300);
        add(trpm_pkg::MODE_EDGE, 32'd1300 + 32'd5000);
        add(trpm_pkg::MODE_TIMEOUT, 32'd500000);
        add(trpm_pkg::MODE_TIMEOUT, 32'hFFFF_FFFF);
        add(trpm_pkg::MODE_EDGE, 32'hFFFF_FF00);
        add(trpm_pkg::MODE_EDGE, 32'h0000_0300);
        add(trpm_pkg::MODE_EDGE, 32'h8000_0000);
        add(trpm_pkg::MODE_EDGE, 32'h8000_1000);
        add(trpm_pkg::MODE_EDGE, 32'h8000_1100);
        add(trpm_pkg::MODE_TIMEOUT, 32'h8000_1200);
        add(trpm_pkg::MODE_TIMEOUT, 32'h0000_0000);
        drain();

        // pause: nothing sent until all results are in, then a zero-threshold setup
        cfg_write(trpm_pkg::REG_TEETH, 32'd1);
        cfg_write(trpm_pkg::REG_DEBOUNCE, 32'd0);
        cfg_write(trpm_pkg::REG_MINPER, 32'd0);
        cfg_write(trpm_pkg::REG_TIMEOUT, 32'd0);
        cfg_write(trpm_pkg::REG_VCOEF, 32'hFF_FFFF);
        t_now = 32'h1000;
        add(trpm_pkg::MODE_EDGE, 32'h1000);
        add(trpm_pkg::MODE_EDGE, 32'h1001);
        add(trpm_pkg::MODE_EDGE, 32'h1002);
        add(trpm_pkg::MODE_EDGE, 32'h2001);
        add(trpm_pkg::MODE_EDGE, 32'h2002);
        add(trpm_pkg::MODE_EDGE, 32'h2002 + 32'd1000000);
        add(trpm_pkg::MODE_TIMEOUT, 32'h0);
        add(trpm_pkg::MODE_EDGE, 32'hFFFF_FFFF);
        drain();

        // random phases over several register settings
        cfg_write(trpm_pkg::REG_TEETH, 32'd20);
        cfg_write(trpm_pkg::REG_DEBOUNCE, 32'd200);
        cfg_write(trpm_pkg::REG_MINPER, 32'd250);
        cfg_write(trpm_pkg::REG_TIMEOUT, 32'd100000);
        cfg_write(trpm_pkg::REG_VCOEF, 32'd1756906);
        t_now = $urandom();
        burst(250, 20000);
        drain();

        cfg_write(trpm_pkg::REG_TEETH, 32'd255);
        cfg_write(trpm_pkg::REG_DEBOUNCE, 32'hFFFF);
        cfg_write(trpm_pkg::REG_MINPER, 32'hFFFF);
        cfg_write(trpm_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
        cfg_write(trpm_pkg::REG_VCOEF, 32'd0);
        burst(150, 200000);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            cfg_write(trpm_pkg::REG_TEETH, $urandom_range(1, 255));
            cfg_write(trpm_pkg::REG_DEBOUNCE, $urandom_range(0, 400));
            cfg_write(trpm_pkg::REG_MINPER, $urandom_range(0, 800));
            cfg_write(trpm_pkg::REG_TIMEOUT, $urandom_range(1000, 60000));
            cfg_write(trpm_pkg::REG_VCOEF, $urandom_range(0, 24'hFF_FFFF));
            if (ph == 2) quiet = 1'b1;
            burst(140, (ph == 1) ? 3000 : 30000);
            drain();
        end

        $display("%0d words checked, %0d pulses accepted, %0d timeouts, 7 register setups",
                 n_checked, n_accepted, n_timeouts);
        if (errors == 0) begin
            $display("tachometer_rpm_acceleration_top_tb: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("tachometer_rpm_acceleration_top_tb: FAIL");
        end
        $finish;
    end

endmodule
